// ----- hw/rtl/nrch_pkg.sv -----
// -----------------------------------------------------------------------------
// nrch_pkg
// Shared types and constants of the nearest ray/circle hit block: sequencer
// step codes, register indexes, and the command and status structs.
// -----------------------------------------------------------------------------
package nrch_pkg;

   typedef logic [5:0] step_type;
   typedef logic [2:0] csr_index_type;

   // multiply sequence steps
   localparam step_type MS_WX    = 6'd0;
   localparam step_type MS_WY    = 6'd1;
   localparam step_type MS_HX    = 6'd2;
   localparam step_type MS_HY    = 6'd3;
   localparam step_type MS_RR    = 6'd4;
   localparam step_type MS_HXWY  = 6'd5;
   localparam step_type MS_HYWX  = 6'd6;
   localparam step_type MS_HXWX  = 6'd7;
   localparam step_type MS_HYWY  = 6'd8;
   localparam step_type MS_K00   = 6'd9;
   localparam step_type MS_K01   = 6'd10;
   localparam step_type MS_K10   = 6'd11;
   localparam step_type MS_K11   = 6'd12;
   localparam step_type MS_Q00   = 6'd13;
   localparam step_type MS_Q01   = 6'd14;
   localparam step_type MS_Q10   = 6'd15;
   localparam step_type MS_Q11   = 6'd16;
   localparam step_type MS_FLUSH = 6'd17;

   // hit point steps
   localparam step_type PS_HX    = 6'd0;
   localparam step_type PS_HY    = 6'd1;
   localparam step_type PS_FLUSH = 6'd2;

   localparam step_type SQ_LAST  = 6'd63;
   localparam step_type DV_LAST  = 6'd30;

   localparam csr_index_type CSR_ORIGIN_X  = 3'd0;
   localparam csr_index_type CSR_ORIGIN_Y  = 3'd1;
   localparam csr_index_type CSR_HEADING_X = 3'd2;
   localparam csr_index_type CSR_HEADING_Y = 3'd3;

   localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic     take;
      logic     prep;
      logic     mul;
      logic     check;
      logic     sqrt;
      logic     ncalc;
      logic     div;
      logic     update;
      logic     point;
      logic     emit;
      step_type step;
   } nrch_cmd_type;

   typedef struct packed {
      logic disc_ok;
      logic n_ok;
      logic n_small;
      logic last;
      logic rsp_free;
   } nrch_sts_type;

endpackage

// ----- hw/rtl/nrch_ctrl.sv -----
// -----------------------------------------------------------------------------
// nrch_ctrl
// Sequencer: walks each circle through multiply, square root, divide and update
// phases as needed and issues step commands to the datapath.
// -----------------------------------------------------------------------------
module nrch_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nrch_pkg::nrch_sts_type sts,
   output nrch_pkg::nrch_cmd_type cmd
);
   import nrch_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_PREP   = 10'b00_0000_0010,
      ST_MUL    = 10'b00_0000_0100,
      ST_CHECK  = 10'b00_0000_1000,
      ST_SQRT   = 10'b00_0001_0000,
      ST_NCALC  = 10'b00_0010_0000,
      ST_DIV    = 10'b00_0100_0000,
      ST_UPDATE = 10'b00_1000_0000,
      ST_POINT  = 10'b01_0000_0000,
      ST_EMIT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   step_type  cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.step = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            if (cnt_ff == MS_FLUSH) begin
               cnt_in   = '0;
               state_in = ST_CHECK;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            state_in  = sts.disc_ok ? ST_SQRT : ST_UPDATE;
         end
         ST_SQRT: begin
            cmd.sqrt = 1'b1;
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = ST_NCALC;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_NCALC: begin
            cmd.ncalc = 1'b1;
            cnt_in    = '0;
            state_in  = (sts.n_ok && sts.n_small) ? ST_DIV : ST_UPDATE;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (cnt_ff == DV_LAST) begin
               cnt_in   = '0;
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = sts.last ? ST_POINT : ST_IDLE;
         end
         ST_POINT: begin
            cmd.point = 1'b1;
            if (cnt_ff == PS_FLUSH) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_take_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PREP))
      else $error("accepted transaction did not start prep");

   a_mul_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && cnt_ff == MS_FLUSH) |=> (state_ff == ST_CHECK))
      else $error("multiply sequence did not end in check");

   a_mid_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && !sts.last) |=> (state_ff == ST_IDLE && !req_stall))
      else $error("non-final circle did not return to idle");

endmodule

// ----- hw/rtl/nrch_dp.sv -----
// -----------------------------------------------------------------------------
// nrch_dp
// Datapath: configuration registers, one shared 33x33 multiplier with
// accumulators, a radix-2 square root, a restoring divider, the nearest hit
// tracking and the result register.
// -----------------------------------------------------------------------------
module nrch_dp #(
   parameter int MAX_CIRCLES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nrch_pkg::nrch_cmd_type cmd,
   output nrch_pkg::nrch_sts_type sts,
   input  logic signed [31:0]     req_center_x,
   input  logic signed [31:0]     req_center_y,
   input  logic [30:0]            req_circle_radius,
   input  logic                   req_last_circle,
   input  logic                   csr_valid,
   input  nrch_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_hit_found,
   output logic                   rsp_origin_inside,
   output logic                   rsp_tie_seen,
   output logic [15:0]            rsp_hit_index,
   output logic [30:0]            rsp_hit_time,
   output logic signed [31:0]     rsp_hit_x,
   output logic signed [31:0]     rsp_hit_y
);
   import nrch_pkg::*;

   localparam logic [15:0] CntLast = 16'(MAX_CIRCLES - 1);

   // configuration
   logic signed [31:0] ox_ff, oy_ff, hx_ff, hy_ff;

   // circle operands
   logic signed [31:0] cx_ff, cy_ff;
   logic [30:0]        rad_ff;
   logic               last_ff;
   logic [32:0]        wxm_ff, wym_ff;
   logic               wxs_ff, wys_ff;
   logic [31:0]        hxm_ff, hym_ff;
   logic               hxs_ff, hys_ff;

   // multiplier and accumulators
   logic [32:0]        mul_a, mul_b;
   logic               mul_neg;
   logic [65:0]        mul_p;
   logic [65:0]        prod_ff;
   logic               pneg_ff;
   logic [66:0]        ww_ff, ww_in;
   logic [63:0]        a_ff, a_in;
   logic [61:0]        r2_ff, r2_in;
   logic signed [65:0] k_ff, k_in, b_ff, b_in, spv;
   logic [127:0]       kk_ff, kk_in, ar2_ff, ar2_in;
   logic [65:0]        kabs_full;
   logic [63:0]        kabs;
   step_type           acc_step;

   // square root, divide
   logic [127:0]       sq_op_ff, sq_op_in, sq_res_ff, sq_res_in, sq_one_ff, sq_one_in;
   logic [127:0]       sq_trial;
   logic [63:0]        sroot;
   logic signed [66:0] nval;
   logic [94:0]        num_w, lim_w;
   logic [94:0]        num_ff, num_in, dsh_ff, dsh_in;
   logic [30:0]        t_ff, t_in;
   logic               cand_ff, cand_in;
   logic               dv_ge;

   // hit point
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [31:0] pt_sat;
   logic signed [31:0] pt_org;
   logic [46:0]        pt_floor;
   logic [63:0]        pt_round;
   logic signed [48:0] pt_fq, pt_sum;

   // set state
   logic               any_ff, any_in, tie_ff, tie_in, inside_ff, inside_in;
   logic [30:0]        best_ff, best_in;
   logic [15:0]        bidx_ff, bidx_in, cnt_ff, cnt_in;

   // result register
   logic               rv_ff;
   logic               r_found_ff, r_inside_ff, r_tie_ff;
   logic [15:0]        r_idx_ff;
   logic [30:0]        r_time_ff;
   logic signed [31:0] r_x_ff, r_y_ff;

   logic signed [32:0] wx_d, wy_d;

   assign wx_d = {ox_ff[31], ox_ff} - {cx_ff[31], cx_ff};
   assign wy_d = {oy_ff[31], oy_ff} - {cy_ff[31], cy_ff};

   assign kabs_full = k_ff[65] ? (66'd0 - k_ff) : k_ff;
   assign kabs      = kabs_full[63:0];
   assign acc_step  = cmd.step - 6'd1;
   assign spv       = pneg_ff ? (66'sd0 - $signed({2'b00, prod_ff[63:0]}))
                              : $signed({2'b00, prod_ff[63:0]});

   // operand select
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      if (cmd.mul) begin
         case (cmd.step)
            MS_WX:   begin mul_a = wxm_ff; mul_b = wxm_ff; end
            MS_WY:   begin mul_a = wym_ff; mul_b = wym_ff; end
            MS_HX:   begin mul_a = {1'b0, hxm_ff}; mul_b = {1'b0, hxm_ff}; end
            MS_HY:   begin mul_a = {1'b0, hym_ff}; mul_b = {1'b0, hym_ff}; end
            MS_RR:   begin mul_a = {2'b00, rad_ff}; mul_b = {2'b00, rad_ff}; end
            MS_HXWY: begin
               mul_a = {1'b0, hxm_ff}; mul_b = wym_ff; mul_neg = hxs_ff ^ wys_ff;
            end
            MS_HYWX: begin
               mul_a = {1'b0, hym_ff}; mul_b = wxm_ff; mul_neg = hys_ff ^ wxs_ff;
            end
            MS_HXWX: begin
               mul_a = {1'b0, hxm_ff}; mul_b = wxm_ff; mul_neg = hxs_ff ^ wxs_ff;
            end
            MS_HYWY: begin
               mul_a = {1'b0, hym_ff}; mul_b = wym_ff; mul_neg = hys_ff ^ wys_ff;
            end
            MS_K00:  begin mul_a = {1'b0, kabs[31:0]};  mul_b = {1'b0, kabs[31:0]};  end
            MS_K01:  begin mul_a = {1'b0, kabs[31:0]};  mul_b = {1'b0, kabs[63:32]}; end
            MS_K10:  begin mul_a = {1'b0, kabs[63:32]}; mul_b = {1'b0, kabs[31:0]};  end
            MS_K11:  begin mul_a = {1'b0, kabs[63:32]}; mul_b = {1'b0, kabs[63:32]}; end
            MS_Q00:  begin mul_a = {1'b0, a_ff[31:0]};  mul_b = {1'b0, r2_ff[31:0]}; end
            MS_Q01:  begin mul_a = {1'b0, a_ff[31:0]};  mul_b = {3'b000, r2_ff[61:32]}; end
            MS_Q10:  begin mul_a = {1'b0, a_ff[63:32]}; mul_b = {1'b0, r2_ff[31:0]}; end
            MS_Q11:  begin mul_a = {1'b0, a_ff[63:32]}; mul_b = {3'b000, r2_ff[61:32]}; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (cmd.point) begin
         case (cmd.step)
            PS_HX:   begin mul_a = {1'b0, hxm_ff}; mul_b = {2'b00, best_ff}; mul_neg = hxs_ff; end
            PS_HY:   begin mul_a = {1'b0, hym_ff}; mul_b = {2'b00, best_ff}; mul_neg = hys_ff; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;

   // square root and divide step logic
   assign sq_trial = sq_res_ff + sq_one_ff;
   assign sroot    = sq_res_ff[63:0] + {63'd0, (sq_op_ff != 128'd0)};
   assign nval     = 67'sd0 - $signed({b_ff[65], b_ff}) - $signed({3'b000, sroot});
   assign num_w    = {13'd0, nval[65:0], 16'd0};
   assign lim_w    = {a_ff, 31'd0};
   assign dv_ge    = (num_ff >= dsh_ff);

   // hit point rounding toward minus infinity, then saturate
   assign pt_floor = prod_ff[62:16];
   assign pt_round = {1'b0, prod_ff[62:0]} + 64'd65535;
   assign pt_fq    = pneg_ff ? (49'sd0 - $signed({1'b0, pt_round[63:16]}))
                             : $signed({2'b00, pt_floor});
   assign pt_org   = (acc_step == PS_HX) ? ox_ff : oy_ff;
   assign pt_sum   = $signed({{17{pt_org[31]}}, pt_org}) + pt_fq;

   always_comb begin
      if (pt_sum > 49'sh0_7FFF_FFFF) begin
         pt_sat = 32'sh7FFF_FFFF;
      end else if (pt_sum < -49'sh0_8000_0000) begin
         pt_sat = -32'sh8000_0000;
      end else begin
         pt_sat = pt_sum[31:0];
      end
   end

   assign sts.disc_ok  = (a_ff != 64'd0) && (ar2_ff >= kk_ff);
   assign sts.n_ok     = !nval[66];
   assign sts.n_small  = (num_w < lim_w);
   assign sts.last     = last_ff;
   assign sts.rsp_free = !rv_ff || !rsp_stall;

   // next values
   always_comb begin
      ww_in     = ww_ff;
      a_in      = a_ff;
      r2_in     = r2_ff;
      k_in      = k_ff;
      b_in      = b_ff;
      kk_in     = kk_ff;
      ar2_in    = ar2_ff;
      sq_op_in  = sq_op_ff;
      sq_res_in = sq_res_ff;
      sq_one_in = sq_one_ff;
      num_in    = num_ff;
      dsh_in    = dsh_ff;
      t_in      = t_ff;
      cand_in   = cand_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      any_in    = any_ff;
      tie_in    = tie_ff;
      inside_in = inside_ff;
      best_in   = best_ff;
      bidx_in   = bidx_ff;
      cnt_in    = cnt_ff;

      if (cmd.prep) begin
         cand_in = 1'b0;
      end

      if (cmd.mul) begin
         case (acc_step)
            MS_WX:   ww_in  = {1'b0, prod_ff};
            MS_WY:   ww_in  = ww_ff + {1'b0, prod_ff};
            MS_HX:   a_in   = prod_ff[63:0];
            MS_HY:   a_in   = a_ff + prod_ff[63:0];
            MS_RR:   r2_in  = prod_ff[61:0];
            MS_HXWY: k_in   = spv;
            MS_HYWX: k_in   = k_ff - spv;
            MS_HXWX: b_in   = spv;
            MS_HYWY: b_in   = b_ff + spv;
            MS_K00:  kk_in  = {64'd0, prod_ff[63:0]};
            MS_K01:  kk_in  = kk_ff + {32'd0, prod_ff[63:0], 32'd0};
            MS_K10:  kk_in  = kk_ff + {32'd0, prod_ff[63:0], 32'd0};
            MS_K11:  kk_in  = kk_ff + {prod_ff[63:0], 64'd0};
            MS_Q00:  ar2_in = {64'd0, prod_ff[63:0]};
            MS_Q01:  ar2_in = ar2_ff + {32'd0, prod_ff[63:0], 32'd0};
            MS_Q10:  ar2_in = ar2_ff + {32'd0, prod_ff[63:0], 32'd0};
            MS_Q11:  ar2_in = ar2_ff + {prod_ff[63:0], 64'd0};
            default: ww_in  = ww_ff;
         endcase
      end

      if (cmd.check) begin
         if ({5'd0, r2_ff} >= ww_ff) begin
            inside_in = 1'b1;
         end
         sq_op_in  = ar2_ff - kk_ff;
         sq_res_in = '0;
         sq_one_in = {2'b01, 126'd0};
      end

      if (cmd.sqrt) begin
         if (sq_op_ff >= sq_trial) begin
            sq_op_in  = sq_op_ff - sq_trial;
            sq_res_in = (sq_res_ff >> 1) + sq_one_ff;
         end else begin
            sq_res_in = sq_res_ff >> 1;
         end
         sq_one_in = sq_one_ff >> 2;
      end

      if (cmd.ncalc) begin
         cand_in = sts.n_ok;
         num_in  = num_w;
         dsh_in  = {1'b0, a_ff, 30'd0};
         t_in    = sts.n_small ? 31'd0 : TIME_MAX;
      end

      if (cmd.div) begin
         if (dv_ge) begin
            num_in = num_ff - dsh_ff;
         end
         t_in   = {t_ff[29:0], dv_ge};
         dsh_in = dsh_ff >> 1;
      end

      if (cmd.update) begin
         if (cand_ff) begin
            if (!any_ff || (t_ff < best_ff)) begin
               any_in  = 1'b1;
               best_in = t_ff;
               bidx_in = cnt_ff;
               tie_in  = 1'b0;
            end else if (t_ff == best_ff) begin
               tie_in = 1'b1;
            end
         end
         cnt_in = (cnt_ff == CntLast) ? 16'd0 : (cnt_ff + 16'd1);
      end

      if (cmd.point) begin
         if (acc_step == PS_HX) begin
            px_in = pt_sat;
         end else if (acc_step == PS_HY) begin
            py_in = pt_sat;
         end
      end

      if (cmd.emit) begin
         any_in    = 1'b0;
         tie_in    = 1'b0;
         inside_in = 1'b0;
         best_in   = '0;
         bidx_in   = '0;
         cnt_in    = '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff   <= mul_p;
      pneg_ff   <= mul_neg;
      ww_ff     <= ww_in;
      a_ff      <= a_in;
      r2_ff     <= r2_in;
      k_ff      <= k_in;
      b_ff      <= b_in;
      kk_ff     <= kk_in;
      ar2_ff    <= ar2_in;
      sq_op_ff  <= sq_op_in;
      sq_res_ff <= sq_res_in;
      sq_one_ff <= sq_one_in;
      num_ff    <= num_in;
      dsh_ff    <= dsh_in;
      t_ff      <= t_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      if (cmd.take) begin
         cx_ff   <= req_center_x;
         cy_ff   <= req_center_y;
         rad_ff  <= req_circle_radius;
         last_ff <= req_last_circle;
      end
      if (cmd.prep) begin
         wxs_ff <= wx_d[32];
         wys_ff <= wy_d[32];
         wxm_ff <= wx_d[32] ? (33'd0 - wx_d) : wx_d;
         wym_ff <= wy_d[32] ? (33'd0 - wy_d) : wy_d;
         hxs_ff <= hx_ff[31];
         hys_ff <= hy_ff[31];
         hxm_ff <= hx_ff[31] ? (32'd0 - hx_ff) : hx_ff;
         hym_ff <= hy_ff[31] ? (32'd0 - hy_ff) : hy_ff;
      end
      if (cmd.emit) begin
         r_found_ff  <= any_ff;
         r_inside_ff <= inside_ff;
         r_tie_ff    <= any_ff & tie_ff;
         r_idx_ff    <= any_ff ? bidx_ff : 16'd0;
         r_time_ff   <= any_ff ? best_ff : 31'd0;
         r_x_ff      <= any_ff ? px_ff : 32'sd0;
         r_y_ff      <= any_ff ? py_ff : 32'sd0;
      end
   end

   // control, configuration and set state
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff     <= '0;
         oy_ff     <= '0;
         hx_ff     <= '0;
         hy_ff     <= '0;
         cand_ff   <= 1'b0;
         any_ff    <= 1'b0;
         tie_ff    <= 1'b0;
         inside_ff <= 1'b0;
         best_ff   <= '0;
         bidx_ff   <= '0;
         cnt_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ORIGIN_X:  ox_ff <= csr_wdata;
               CSR_ORIGIN_Y:  oy_ff <= csr_wdata;
               CSR_HEADING_X: hx_ff <= csr_wdata;
               CSR_HEADING_Y: hy_ff <= csr_wdata;
               default:       ox_ff <= ox_ff;
            endcase
         end
         cand_ff   <= cand_in;
         any_ff    <= any_in;
         tie_ff    <= tie_in;
         inside_ff <= inside_in;
         best_ff   <= best_in;
         bidx_ff   <= bidx_in;
         cnt_ff    <= cnt_in;
         if (cmd.emit) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_hit_found     = r_found_ff;
   assign rsp_origin_inside = r_inside_ff;
   assign rsp_tie_seen      = r_tie_ff;
   assign rsp_hit_index     = r_idx_ff;
   assign rsp_hit_time      = r_time_ff;
   assign rsp_hit_x         = r_x_ff;
   assign rsp_hit_y         = r_y_ff;

endmodule

// ----- hw/rtl/nearest_ray_circle_hit.sv -----
// -----------------------------------------------------------------------------
// nearest_ray_circle_hit
// Nearest ray/circle intersection over a stream of circles, Q16.16.
// -----------------------------------------------------------------------------
// The ray origin and heading sit in four configuration registers. Circles are
// taken one at a time; each runs through 18 multiply steps on one shared
// 33x33 multiplier, a 64-step square root and, when the circle is hit ahead
// of the origin and the hit time does not saturate, a 31-step divide. A
// circle marked last then runs the hit point steps and loads one result into
// the output register, which holds it while the next set is already being
// taken in.
// -----------------------------------------------------------------------------
module nearest_ray_circle_hit #(
   parameter int MAX_CIRCLES = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_center_x,
   input  logic signed [31:0]      req_center_y,
   input  logic [30:0]             req_circle_radius,
   input  logic                    req_last_circle,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit_found,
   output logic                    rsp_origin_inside,
   output logic                    rsp_tie_seen,
   output logic [15:0]             rsp_hit_index,
   output logic [30:0]             rsp_hit_time,
   output logic signed [31:0]      rsp_hit_x,
   output logic signed [31:0]      rsp_hit_y,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  nrch_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata
);
   import nrch_pkg::*;

   nrch_cmd_type cmd;
   nrch_sts_type sts;

   assign csr_ready = 1'b1;

   nrch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   nrch_dp #(
      .MAX_CIRCLES (MAX_CIRCLES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_circle_radius (req_circle_radius),
      .req_last_circle   (req_last_circle),
      .csr_valid         (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_hit_found     (rsp_hit_found),
      .rsp_origin_inside (rsp_origin_inside),
      .rsp_tie_seen      (rsp_tie_seen),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_hit_time      (rsp_hit_time),
      .rsp_hit_x         (rsp_hit_x),
      .rsp_hit_y         (rsp_hit_y)
   );

endmodule

// ----- dv/nearest_ray_circle_hit_tb.sv -----
// -----------------------------------------------------------------------------
// nearest_ray_circle_hit_tb
// Self-checking testbench for the nearest ray/circle hit block. A scoreboard
// class tracks the ray setup and the per-set hit state in exact wide integers.
// It predicts one result per closed circle set and checks every result
// transaction field by field. Plain tasks drive the circle stream and the
// register port under three idle/stall mixes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_ray_circle_hit_tb;
   import nrch_pkg::*;

   localparam csr_index_type CSR_UNUSED = 3'd5;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        radius;
      logic               last;
   } circle_type;

   typedef struct {
      logic               found;
      logic               origin_in;
      logic               tie;
      logic [15:0]        index;
      logic [30:0]        t;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } hit_type;

   class hit_scoreboard;
      logic signed [31:0] ox, oy, hx, hy;
      logic [30:0]        best_t;
      logic [15:0]        best_idx, count;
      logic               any_hit, tie_flag, inside_flag;
      hit_type            expected_hits[$];
      int                 errors, results, hits;

      function void clear_set();
         best_t = 0; best_idx = 0; any_hit = 0;
         tie_flag = 0; inside_flag = 0; count = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_ORIGIN_X:  ox = v;
            CSR_ORIGIN_Y:  oy = v;
            CSR_HEADING_X: hx = v;
            CSR_HEADING_Y: hy = v;
            default: ;
         endcase
      endfunction

      function logic signed [31:0] sat(logic signed [159:0] v);
         if (v > 160'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -160'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function void note(circle_type c);
         logic signed [159:0] wx, wy, rr, r2, a, ww, ar2, k, kk, disc, b, n, num, cw, tt;
         logic [63:0] s, cand;
         logic [30:0] t;
         hit_type h;
         wx = ox - c.cx;
         wy = oy - c.cy;
         rr = c.radius;
         r2 = rr * rr;
         a = hx * hx + hy * hy;
         ww = wx * wx + wy * wy;
         if (ww <= r2) inside_flag = 1;
         if (a != 0) begin
            ar2 = a * r2;
            k = hx * wy - hy * wx;
            kk = k * k;
            if (ar2 >= kk) begin
               disc = ar2 - kk;
               s = 0;
               for (int bit_n = 62; bit_n >= 0; bit_n--) begin
                  cand = s | (64'd1 << bit_n);
                  cw = cand;
                  if (cw * cw <= disc) s = cand;
               end
               cw = s;
               if (cw * cw < disc) s = s + 1;
               cw = s;
               b = hx * wx + hy * wy;
               n = -b - cw;
               if (n >= 0) begin
                  num = n <<< 16;
                  if (num >= (a <<< 31)) t = TIME_MAX;
                  else t = 31'(num / a);
                  if (!any_hit || t < best_t) begin
                     any_hit = 1; best_t = t; best_idx = count; tie_flag = 0;
                  end else if (t == best_t) begin
                     tie_flag = 1;
                  end
               end
            end
         end
         count = count + 16'd1;
         if (c.last) begin
            h = '{default: 0};
            h.found = any_hit;
            h.origin_in = inside_flag;
            if (any_hit) begin
               tt = best_t;
               h.tie = tie_flag;
               h.index = best_idx;
               h.t = best_t;
               h.px = sat(ox + ((hx * tt) >>> 16));
               h.py = sat(oy + ((hy * tt) >>> 16));
            end
            expected_hits.push_back(h);
            clear_set();
         end
      endfunction

      function void check(hit_type act);
         hit_type e;
         bit      bad;
         bad = 0;
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result transaction", $time);
            errors++;
            return;
         end
         e = expected_hits.pop_front();
         results++;
         if (act.found) hits++;
         if (act.found !== e.found) begin
            $display("%0t: hit_found exp %0d act %0d", $time, e.found, act.found);
            bad = 1;
         end
         if (act.origin_in !== e.origin_in) begin
            $display("%0t: origin_inside exp %0d act %0d", $time, e.origin_in,
                     act.origin_in);
            bad = 1;
         end
         if (act.tie !== e.tie) begin
            $display("%0t: tie_seen exp %0d act %0d", $time, e.tie, act.tie);
            bad = 1;
         end
         if (act.index !== e.index) begin
            $display("%0t: hit_index exp %0d act %0d", $time, e.index, act.index);
            bad = 1;
         end
         if (act.t !== e.t) begin
            $display("%0t: hit_time exp %h act %h", $time, e.t, act.t);
            bad = 1;
         end
         if (act.px !== e.px) begin
            $display("%0t: hit_x exp %h act %h", $time, e.px, act.px);
            bad = 1;
         end
         if (act.py !== e.py) begin
            $display("%0t: hit_y exp %h act %h", $time, e.py, act.py);
            bad = 1;
         end
         if (bad) errors++;
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic signed [31:0]   req_center_x = 0;
   logic signed [31:0]   req_center_y = 0;
   logic [30:0]          req_circle_radius = 0;
   logic                 req_last_circle = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic                 rsp_hit_found;
   logic                 rsp_origin_inside;
   logic                 rsp_tie_seen;
   logic [15:0]          rsp_hit_index;
   logic [30:0]          rsp_hit_time;
   logic signed [31:0]   rsp_hit_x;
   logic signed [31:0]   rsp_hit_y;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_ORIGIN_X;
   logic [31:0]          csr_wdata = 0;

   hit_scoreboard sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycles = 0;
   int circles_sent = 0;
   circle_type prev_circle;

   nearest_ray_circle_hit dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("nearest_ray_circle_hit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      hit_type act;
      if (!reset && rsp_valid && !rsp_stall) begin
         act.found = rsp_hit_found;
         act.origin_in = rsp_origin_inside;
         act.tie = rsp_tie_seen;
         act.index = rsp_hit_index;
         act.t = rsp_hit_time;
         act.px = rsp_hit_x;
         act.py = rsp_hit_y;
         sb.check(act);
      end
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic send(circle_type c);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_center_x <= c.cx;
      req_center_y <= c.cy;
      req_circle_radius <= c.radius;
      req_last_circle <= c.last;
      do @(posedge clock); while (req_stall);
      sb.note(c);
      prev_circle = c;
      circles_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] hx, logic [31:0] hy);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_HEADING_X, hx);
      write_reg(CSR_HEADING_Y, hy);
   endtask

   function automatic circle_type mk(int cx, int cy, int r, bit last);
      circle_type c;
      c.cx = cx; c.cy = cy; c.radius = 31'(r); c.last = last;
      return c;
   endfunction

   function automatic int spread(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // circles placed near the ray so that most are hit; a few are pure noise
   function automatic circle_type ray_circle(bit last);
      circle_type c;
      longint tq;
      int roll;
      roll = $urandom_range(99);
      if (roll < 8 && circles_sent > 0) begin
         c = prev_circle;
      end else if (roll < 22) begin
         c.cx = $urandom;
         c.cy = $urandom;
         c.radius = 31'({$urandom} >> 1);
      end else begin
         tq = longint'($urandom_range(0, 6 << 16)) - longint'(1 << 16);
         c.cx = 32'(sb.ox + ((longint'(sb.hx) * tq) >>> 16) + spread(1 << 16));
         c.cy = 32'(sb.oy + ((longint'(sb.hy) * tq) >>> 16) + spread(1 << 16));
         c.radius = 31'($urandom_range(0, 3 << 16));
      end
      c.last = last;
      return c;
   endfunction

   task automatic random_ray();
      if ($urandom_range(9) == 0) begin
         set_ray($urandom, $urandom, $urandom, $urandom);
      end else begin
         set_ray(spread(1 << 22), spread(1 << 22), spread(1 << 17), spread(1 << 17));
      end
   endtask

   initial begin
      int budget;
      int set_len;
      sb.ox = 0; sb.oy = 0; sb.hx = 0; sb.hy = 0;
      sb.clear_set();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero heading: only the inside test can fire
      send(mk(0, 0, 1 << 16, 0));
      send(mk(5 << 16, 0, 1 << 16, 1));
      drain();

      // unit heading along x
      set_ray(0, 0, 1 << 16, 0);
      write_reg(CSR_UNUSED, 32'hDEAD_BEEF);
      send(mk(8 << 16, 0, 1 << 16, 0));
      send(mk(-5 << 16, 0, 1 << 16, 0));
      send(mk(5 << 16, 0, 1 << 16, 0));
      send(mk(5 << 16, 0, 1 << 16, 0));
      send(mk(0, 0, 2 << 16, 0));
      send(mk(3 << 16, 0, 0, 0));
      send(mk(3 << 16, 1 << 16, 1 << 16, 1));
      send(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0));
      send(mk(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 1));
      send(mk(32'sh8000_0000, 0, 0, 1));
      drain();

      // tiny heading: hit time saturates
      set_ray(0, 0, 1, 0);
      send(mk(32'sh7FFF_FFFF, 0, 1 << 16, 1));
      drain();

      // extreme ray: hit point saturates
      set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 0));
      send(mk(0, 0, 31'h7FFF_FFFF, 1));
      drain();
      set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0));
      send(mk(0, 0, 31'h4000_0000, 1));
      drain();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 60 : 0;
         rsp_stall_pct = (mode == 0) ? 60 : (mode == 1) ? 31 : 0;
         budget = 670;
         while (budget > 0) begin
            random_ray();
            for (int s = 0; s < 8 && budget > 0; s++) begin
               set_len = ($urandom_range(19) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
               for (int i = 0; i < set_len; i++) begin
                  send(ray_circle(i == set_len - 1));
                  budget--;
               end
            end
            drain();
         end
      end

      $display("Circles sent: %0d, sets checked: %0d, sets with a hit: %0d",
               circles_sent, sb.results, sb.hits);
      if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
         $display("nearest_ray_circle_hit regression: pass");
      end else begin
         $display("nearest_ray_circle_hit regression: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/nrch_pkg.sv
hw/rtl/nrch_ctrl.sv
hw/rtl/nrch_dp.sv
hw/rtl/nearest_ray_circle_hit.sv
dv/nearest_ray_circle_hit_tb.sv
